@@ src/scba_pkg.sv @@
// Shared types and constants for the size-class bitmap slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing else.
package scba_pkg;

   localparam int DefPoolLevels  = 4;
   localparam int DefSlotsPerPool = 64;

   // Fixed field widths of the stream and configuration words.
   localparam int BytesW  = 13;
   localparam int InLvlW  = 3;
   localparam int StatusW = 3;
   localparam int SlotOutW = 6;
   localparam int GrantW  = 14;
   localparam int LvlOutW = 2;
   localparam int CsrDataW = 13;
   localparam int CsrIdxW  = 1;
   localparam int ReqDataW = 16;
   localparam int RspDataW = 32;

   localparam int SlotBytesLog2 = 4;     // slots are 16 bytes apart
   localparam int RingAlignMask = 255;   // ring sizes round up to 256 bytes
   localparam int LargeBytes    = 4096;  // the single large buffer
   localparam int ThresholdReset = 32;

   localparam logic [CsrIdxW-1:0] CSR_RING_ENABLED   = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_RING_THRESHOLD = 1'b1;

   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef enum logic [StatusW-1:0] {
      ST_SMALL     = 3'd0,
      ST_LARGE     = 3'd1,
      ST_RING      = 3'd2,
      ST_BADSIZE   = 3'd3,
      ST_EXHAUSTED = 3'd4,
      ST_CLEARED   = 3'd5
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the accepted request word
      logic exec;   // decide, update the maps and load the result register
   } cmd_type;

endpackage

@@ src/scba_ctrl.sv @@
// Controller of the slot allocator: request handshake, two-step sequencing and result valid.
// Depends on scba_pkg for the command struct.
module scba_ctrl
   import scba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      valid_ff;
   logic      room;

   // The result register may be refilled when empty or when its word leaves now.
   assign room       = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign cmd.load   = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.exec   = (state_ff == S_EXEC) && room;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_EXEC;
               end
               if (rsp_tready) begin
                  valid_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (room) begin
                  state_ff <= S_IDLE;
                  valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

@@ src/scba_dp.sv @@
// Datapath of the slot allocator: configuration, request register, used maps,
// first-free search and the result register. Depends on scba_pkg.
module scba_dp
   import scba_pkg::*;
#(
   parameter int POOL_LEVELS    = DefPoolLevels,
   parameter int SLOTS_PER_POOL = DefSlotsPerPool
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tuser,
   output logic [RspDataW-1:0] rsp_tdata
);

   localparam int LvlW  = (POOL_LEVELS > 1) ? $clog2(POOL_LEVELS) : 1;
   localparam int SlotW = $clog2(SLOTS_PER_POOL);
   localparam int StartW = BytesW - SlotBytesLog2 + 1;
   localparam logic [InLvlW:0] MaxLvl = (InLvlW + 1)'(POOL_LEVELS - 1);

   logic                    ring_en_ff;
   logic [CsrDataW-1:0]     ring_thr_ff;
   logic                    func_ff;
   logic [BytesW-1:0]       size_ff;
   logic [InLvlW-1:0]       lvl_ff;
   logic [InLvlW-1:0]       lvl_in;
   logic [SLOTS_PER_POOL-1:0] maps_ff [POOL_LEVELS];

   logic [StatusW-1:0]      status_ff, status_in;
   logic [SlotOutW-1:0]     slot_ff, slot_in;
   logic [GrantW-1:0]       grant_ff, grant_in;
   logic [LvlOutW-1:0]      level_ff;

   logic [GrantW-1:0]       ceil16, ring_bytes;
   logic [StartW-1:0]       start;
   logic [SLOTS_PER_POOL-1:0] cur_map, free_mask, first_free;
   logic [SlotW-1:0]        found_slot;
   logic                    any_free, take_slot;

   // Clamp the pool level as the request is captured.
   assign lvl_in = ({1'b0, req_tdata[ReqDataW-1:BytesW]} > MaxLvl)
                   ? MaxLvl[InLvlW-1:0] : req_tdata[ReqDataW-1:BytesW];

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_en_ff  <= 1'b0;
         ring_thr_ff <= CsrDataW'(ThresholdReset);
      end else if (csr_we) begin
         case (csr_index)
            CSR_RING_ENABLED:   ring_en_ff  <= csr_wdata[0];
            CSR_RING_THRESHOLD: ring_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tuser;
         size_ff <= req_tdata[BytesW-1:0];
         lvl_ff  <= lvl_in;
      end
   end

   // Size rounding and start slot.
   assign ceil16     = GrantW'(size_ff) + GrantW'(15);
   assign start      = ceil16[GrantW-1:SlotBytesLog2];
   assign ring_bytes = (GrantW'(size_ff) + GrantW'(RingAlignMask))
                       & ~GrantW'(RingAlignMask);

   // First free slot at or above the start slot.
   assign cur_map = maps_ff[lvl_ff[LvlW-1:0]];
   always_comb begin
      for (int i = 0; i < SLOTS_PER_POOL; i++) begin
         free_mask[i] = !cur_map[i] && (StartW'(i) >= start);
      end
   end
   assign first_free = free_mask & (~free_mask + SLOTS_PER_POOL'(1));
   assign any_free   = |free_mask;
   always_comb begin
      found_slot = '0;
      for (int i = 0; i < SLOTS_PER_POOL; i++) begin
         if (first_free[i]) begin
            found_slot = found_slot | SlotW'(i);
         end
      end
   end

   always_comb begin
      status_in = ST_EXHAUSTED;
      slot_in   = '0;
      grant_in  = '0;
      take_slot = 1'b0;
      if (func_ff == FUNC_RELEASE) begin
         status_in = ST_CLEARED;
      end else if (ring_en_ff && (size_ff > ring_thr_ff)) begin
         status_in = ST_RING;
         grant_in  = ring_bytes;
      end else if ((size_ff == '0) || (GrantW'(size_ff) > GrantW'(LargeBytes))) begin
         status_in = ST_BADSIZE;
      end else if (start > StartW'(SLOTS_PER_POOL - 1)) begin
         status_in = ST_LARGE;
         grant_in  = GrantW'(LargeBytes);
      end else if (any_free) begin
         status_in = ST_SMALL;
         slot_in   = SlotOutW'(found_slot);
         grant_in  = GrantW'(found_slot) << SlotBytesLog2;
         take_slot = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < POOL_LEVELS; p++) begin
            maps_ff[p] <= '0;
         end
      end else if (cmd.exec) begin
         if (func_ff == FUNC_RELEASE) begin
            for (int p = 0; p < POOL_LEVELS; p++) begin
               maps_ff[p] <= '0;
            end
         end else if (take_slot) begin
            maps_ff[lvl_ff[LvlW-1:0]] <= cur_map | first_free;
         end
      end
   end

   // The level is held with the rest of the result, so a request captured while the
   // word waits cannot change it.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         grant_ff  <= grant_in;
         level_ff  <= lvl_ff[LvlOutW-1:0];
      end
   end

   // Result word: status, slot, granted_bytes, level_used, zero fill.
   assign rsp_tdata = {
      (RspDataW - StatusW - SlotOutW - GrantW - LvlOutW)'(0),
      level_ff, grant_ff, slot_ff, status_ff
   };

endmodule

@@ src/size_class_bitmap_allocator_unit.sv @@
// Top level of the size-class bitmap slot allocator.
// Joins scba_ctrl and scba_dp; depends on scba_pkg.
//
//   channel | direction | accepted when              | word contents
//   req     | in        | req_tvalid && req_tready   | size, pool level; tuser = func
//   rsp     | out       | rsp_tvalid && rsp_tready   | status, slot, granted bytes, level
//   csr     | in        | csr_we                     | index 0 ring enable, 1 threshold
//
// Each request is first captured into the request register; then, in the execute
// state, the first-free search over the selected used map (SLOTS_PER_POOL bits, 64
// by default) runs, the map is updated and the result register is loaded. Reset is
// synchronous; it clears all used maps, ring enable and valid; threshold resets to 32.
// A waiting result does not stop a new request from being accepted; only the second
// step waits, while the result register still holds a word that has not been taken.
module size_class_bitmap_allocator_unit
   import scba_pkg::*;
#(
   parameter int POOL_LEVELS    = DefPoolLevels,
   parameter int SLOTS_PER_POOL = DefSlotsPerPool
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // [12:0] request_bytes, [15:13] pool_level
   input  logic                req_tuser,   // [0] func
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [2:0] status, [8:3] slot,
                                            // [22:9] granted_bytes, [24:23] level_used
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cmd_type cmd;

   scba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   scba_dp #(
      .POOL_LEVELS    (POOL_LEVELS),
      .SLOTS_PER_POOL (SLOTS_PER_POOL)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

`ifndef ASSERT_OFF
   // The block holds only one request in flight.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another was in flight");

   // Only a small grant carries a slot number.
   a_slot_only_small: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:0] != ST_SMALL)) |-> (rsp_tdata[8:3] == '0))
      else $error("slot given without a small grant");

   // Errors grant nothing.
   a_error_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tdata[2:0] == ST_BADSIZE) || (rsp_tdata[2:0] == ST_EXHAUSTED)))
      |-> (rsp_tdata[22:9] == '0))
      else $error("bytes granted on an error result");
`endif

endmodule
